// ===== hw/rtl/kremap_pkg.sv =====
package kremap_pkg;

  // Table and button counts
  localparam int NumMappings = 64;
  localparam int NumVirtual  = 32;
  localparam int NumDevices  = 16;

  // Field widths of the request and event channels
  localparam int ReqW   = 2;
  localparam int DevW   = 4;
  localparam int KeyW   = 8;
  localparam int IdxW   = 5;
  localparam int SlotW  = 6;
  localparam int CoordW = 16;

  localparam int MapAw = (NumMappings > 1) ? $clog2(NumMappings) : 1;
  localparam int BtnW  = (NumVirtual > 1) ? $clog2(NumVirtual) : 1;

  typedef enum logic [ReqW-1:0] {
    ReqKey    = 2'd0,
    ReqMap    = 2'd1,
    ReqEnable = 2'd2,
    ReqFrame  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    StIdle,
    StKeyScan,
    StKeyDrain,
    StFrame
  } state_e;

  typedef struct packed {
    logic [DevW-1:0] dev;
    logic [KeyW-1:0] key;
    logic [IdxW-1:0] button;
  } map_entry_t;

  localparam int EntryW = $bits(map_entry_t);

endpackage

// ===== hw/rtl/kremap_if.sv =====
interface kremap_req_if;
  logic                               valid;
  logic                               ready;
  logic [kremap_pkg::ReqW-1:0]        req_type;
  logic [kremap_pkg::DevW-1:0]        device_id;
  logic [kremap_pkg::KeyW-1:0]        key_code;
  logic                               key_pressed;
  logic [kremap_pkg::IdxW-1:0]        target_index;
  logic [kremap_pkg::SlotW-1:0]       map_slot;
  logic                               entry_valid;
  logic                               down_enable;
  logic                               up_enable;
  logic                               suppress_events;
  logic signed [kremap_pkg::CoordW-1:0] pointer_x;
  logic signed [kremap_pkg::CoordW-1:0] pointer_y;

  modport source (
    output valid, req_type, device_id, key_code, key_pressed, target_index, map_slot,
           entry_valid, down_enable, up_enable, suppress_events, pointer_x, pointer_y,
    input  ready
  );
  modport sink (
    input  valid, req_type, device_id, key_code, key_pressed, target_index, map_slot,
           entry_valid, down_enable, up_enable, suppress_events, pointer_x, pointer_y,
    output ready
  );
endinterface

interface kremap_evt_if;
  logic                                 valid;
  logic                                 ready;
  logic [kremap_pkg::IdxW-1:0]          button_index;
  logic                                 is_press;
  logic signed [kremap_pkg::CoordW-1:0] event_x;
  logic signed [kremap_pkg::CoordW-1:0] event_y;
  logic                                 last;

  modport source (
    output valid, button_index, is_press, event_x, event_y, last,
    input  ready
  );
  modport sink (
    input  valid, button_index, is_press, event_x, event_y, last,
    output ready
  );
endinterface

// ===== hw/rtl/kremap_ram.sv =====
module kremap_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/key_remap_edge_event_generator.sv =====
// Key remap and press/release event generator.
// Request channel (req_i): one item per transfer. A pressed-key sample from
// a device below NumDevices scans the whole mapping table, one entry per cycle
// through a single comparator, and sets the virtual button of every matching
// valid entry. Mapping loads, enable writes, other key samples, and frame
// ends that are suppressed or have no enabled edge finish in the cycle of
// the transfer. A frame end walks the virtual buttons in ascending order,
// one per cycle unless an event stalls, and issues one event per enabled edge.
// Event channel (evt_o): one event per transfer from an output register;
// last marks the final event of a frame end. A frame end with no enabled
// edges issues nothing. While the event receiver stalls, the walk holds at
// each edge to issue; requests are still taken while the last event waits.
// req_i.ready is high only while no request is in progress.
// Reset clears all mapping valid bits, button states and event enables;
// the mapping RAM contents themselves need no clearing.
module key_remap_edge_event_generator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  kremap_req_if.sink  req_i,
  kremap_evt_if.source evt_o
);
  import kremap_pkg::*;

  state_e state_q, state_d;

  logic                  req_ready;
  logic                  scan_rd;
  logic                  accept;

  logic [MapAw-1:0]      idx_q, idx_d;
  logic [BtnW-1:0]       btn_q, btn_d;
  logic                  rd_vld_q, rd_vld_d;
  logic                  rd_hit_q, rd_hit_d;
  logic [NumMappings-1:0] map_vld_q, map_vld_d;
  logic [NumVirtual-1:0] cur_q, cur_d;
  logic [NumVirtual-1:0] prev_q, prev_d;
  logic [NumVirtual-1:0] pen_q, pen_d;
  logic [NumVirtual-1:0] ren_q, ren_d;
  logic [NumVirtual-1:0] fire_q, fire_d;
  logic [NumVirtual-1:0] now_q, now_d;
  logic [NumVirtual-1:0] fire_calc;
  logic [NumVirtual-1:0] btn_onehot;

  logic [DevW-1:0]            dev_q, dev_d;
  logic [KeyW-1:0]            key_q, key_d;
  logic signed [CoordW-1:0]   px_q, px_d;
  logic signed [CoordW-1:0]   py_q, py_d;

  logic                       evt_valid_q, evt_valid_d;
  logic [IdxW-1:0]            evt_idx_q, evt_idx_d;
  logic                       evt_press_q, evt_press_d;
  logic signed [CoordW-1:0]   evt_x_q, evt_x_d;
  logic signed [CoordW-1:0]   evt_y_q, evt_y_d;
  logic                       evt_last_q, evt_last_d;

  logic                  ram_we;
  map_entry_t            ram_wdata;
  map_entry_t            ram_rdata;

  logic                  key_go;
  logic                  frame_go;
  logic                  fire_now;
  logic                  out_free;
  logic                  emit;
  logic                  last_evt;
  logic                  scan_end;

  kremap_ram #(
    .Width (EntryW),
    .Depth (NumMappings)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (MapAw'(req_i.map_slot)),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Status decode
  assign accept     = req_i.valid && req_ready;
  assign fire_calc  = (cur_q & ~prev_q & pen_q) | (~cur_q & prev_q & ren_q);
  assign key_go     = (req_i.req_type == ReqKey) && req_i.key_pressed &&
                      (int'(req_i.device_id) < NumDevices);
  assign frame_go   = (req_i.req_type == ReqFrame) && !req_i.suppress_events &&
                      (fire_calc != '0);
  assign scan_end   = (idx_q == MapAw'(NumMappings - 1));
  assign btn_onehot = NumVirtual'(1) << btn_q;
  assign fire_now   = fire_q[btn_q];
  assign out_free   = !evt_valid_q || evt_o.ready;
  assign emit       = (state_q == StFrame) && fire_now && out_free;
  assign last_evt   = ((fire_q & ~btn_onehot) == '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept && key_go) begin
          state_d = StKeyScan;
        end else if (accept && frame_go) begin
          state_d = StFrame;
        end
      end
      StKeyScan: begin
        if (scan_end) begin
          state_d = StKeyDrain;
        end
      end
      StKeyDrain: begin
        state_d = StIdle;
      end
      StFrame: begin
        if (emit && last_evt) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State outputs
  always_comb begin
    req_ready = 1'b0;
    scan_rd   = 1'b0;
    case (state_q)
      StIdle:     req_ready = 1'b1;
      StKeyScan:  scan_rd   = 1'b1;
      StKeyDrain: scan_rd   = 1'b0;
      StFrame:    scan_rd   = 1'b0;
      default: begin
        req_ready = 1'b0;
        scan_rd   = 1'b0;
      end
    endcase
  end

  // Datapath
  always_comb begin
    idx_d       = idx_q;
    btn_d       = btn_q;
    rd_vld_d    = scan_rd;
    rd_hit_d    = map_vld_q[idx_q];
    map_vld_d   = map_vld_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    pen_d       = pen_q;
    ren_d       = ren_q;
    fire_d      = fire_q;
    now_d       = now_q;
    dev_d       = dev_q;
    key_d       = key_q;
    px_d        = px_q;
    py_d        = py_q;
    evt_valid_d = evt_valid_q && !evt_o.ready;
    evt_idx_d   = evt_idx_q;
    evt_press_d = evt_press_q;
    evt_x_d     = evt_x_q;
    evt_y_d     = evt_y_q;
    evt_last_d  = evt_last_q;
    ram_we      = 1'b0;
    ram_wdata   = '{dev: req_i.device_id, key: req_i.key_code, button: req_i.target_index};

    if (accept) begin
      idx_d = '0;
      btn_d = '0;
      dev_d = req_i.device_id;
      key_d = req_i.key_code;
      px_d  = req_i.pointer_x;
      py_d  = req_i.pointer_y;
      case (req_i.req_type)
        ReqMap: begin
          if (int'(req_i.map_slot) < NumMappings) begin
            ram_we = 1'b1;
            map_vld_d[MapAw'(req_i.map_slot)] = req_i.entry_valid;
          end
        end
        ReqEnable: begin
          if (int'(req_i.target_index) < NumVirtual) begin
            pen_d[BtnW'(req_i.target_index)] = req_i.down_enable;
            ren_d[BtnW'(req_i.target_index)] = req_i.up_enable;
          end
        end
        ReqFrame: begin
          // Snapshot edges, then advance the frame state
          fire_d = req_i.suppress_events ? '0 : fire_calc;
          now_d  = cur_q;
          prev_d = cur_q;
          cur_d  = '0;
        end
        default: begin
          idx_d = '0;
        end
      endcase
    end

    if (scan_rd && !scan_end) begin
      idx_d = idx_q + MapAw'(1);
    end

    // Compare the entry read in the previous cycle
    if (rd_vld_q && rd_hit_q && (ram_rdata.dev == dev_q) && (ram_rdata.key == key_q) &&
        (int'(ram_rdata.button) < NumVirtual)) begin
      cur_d[BtnW'(ram_rdata.button)] = 1'b1;
    end

    if (state_q == StFrame) begin
      if (emit) begin
        evt_valid_d = 1'b1;
        evt_idx_d   = IdxW'(btn_q);
        evt_press_d = now_q[btn_q];
        evt_x_d     = px_q;
        evt_y_d     = py_q;
        evt_last_d  = last_evt;
        fire_d      = fire_q & ~btn_onehot;
      end
      // Hold on a stalled event, else advance
      if (!(fire_now && !out_free)) begin
        btn_d = btn_q + BtnW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      btn_q       <= '0;
      rd_vld_q    <= 1'b0;
      map_vld_q   <= '0;
      cur_q       <= '0;
      prev_q      <= '0;
      pen_q       <= '0;
      ren_q       <= '0;
      fire_q      <= '0;
      evt_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      btn_q       <= btn_d;
      rd_vld_q    <= rd_vld_d;
      map_vld_q   <= map_vld_d;
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      pen_q       <= pen_d;
      ren_q       <= ren_d;
      fire_q      <= fire_d;
      evt_valid_q <= evt_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_hit_q    <= rd_hit_d;
    now_q       <= now_d;
    dev_q       <= dev_d;
    key_q       <= key_d;
    px_q        <= px_d;
    py_q        <= py_d;
    evt_idx_q   <= evt_idx_d;
    evt_press_q <= evt_press_d;
    evt_x_q     <= evt_x_d;
    evt_y_q     <= evt_y_d;
    evt_last_q  <= evt_last_d;
  end

  assign req_i.ready        = req_ready;
  assign evt_o.valid        = evt_valid_q;
  assign evt_o.button_index = evt_idx_q;
  assign evt_o.is_press     = evt_press_q;
  assign evt_o.event_x      = evt_x_q;
  assign evt_o.event_y      = evt_y_q;
  assign evt_o.last         = evt_last_q;

`ifndef SYNTHESIS
  // The button walk never idles in the frame state with nothing left to issue
  a_frame_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFrame) |-> (fire_q != '0))
    else $error("frame walk with empty edge mask");

  // A final event leaves no pending edges behind
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_evt) |=> (fire_q == '0))
    else $error("last event with edges still pending");

  // Table read data is only consumed right after a scan read
  a_rd_follows_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q == StKeyScan))
    else $error("table compare without a scan read");
`endif

endmodule
